>>> rtl/core/uhid_pkg.sv
package uhid_pkg;

   localparam int EP0_PACKET_BYTES_DEF   = 32;
   localparam int NUM_ENDPOINTS_DEF      = 6;
   localparam int DESC_TABLE_ENTRIES_DEF = 9;
   localparam int MAX_PACKET             = 32;
   localparam int ROM_DEPTH              = 256;
   localparam int ROM_USED               = 229;

   localparam logic [1:0] OP_SETUP = 2'd0;
   localparam logic [1:0] OP_IN    = 2'd1;
   localparam logic [1:0] OP_OUT   = 2'd2;
   localparam logic [1:0] OP_RESET = 2'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_DATA  = 2'd1;
   localparam logic [1:0] KIND_ZLP   = 2'd2;
   localparam logic [1:0] KIND_STALL = 2'd3;

   localparam logic [1:0] CSR_VID = 2'd0;
   localparam logic [1:0] CSR_PID = 2'd1;

   localparam logic [7:0] REQ_GET_STATUS     = 8'h00;
   localparam logic [7:0] REQ_CLEAR_FEATURE  = 8'h01;
   localparam logic [7:0] REQ_SET_FEATURE    = 8'h03;
   localparam logic [7:0] REQ_SET_ADDRESS    = 8'h05;
   localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
   localparam logic [7:0] REQ_GET_CONFIG     = 8'h08;
   localparam logic [7:0] REQ_SET_CONFIG     = 8'h09;
   localparam logic [7:0] CLS_GET_IDLE       = 8'h02;
   localparam logic [7:0] CLS_GET_PROTOCOL   = 8'h03;
   localparam logic [7:0] CLS_SET_REPORT     = 8'h09;
   localparam logic [7:0] CLS_SET_IDLE       = 8'h0a;
   localparam logic [7:0] CLS_SET_PROTOCOL   = 8'h0b;

   localparam logic [7:0] RT_STD_OUT    = 8'h00;
   localparam logic [7:0] RT_STD_IN     = 8'h80;
   localparam logic [7:0] RT_EP_OUT     = 8'h02;
   localparam logic [7:0] RT_EP_IN      = 8'h82;
   localparam logic [7:0] RT_CLASS_OUT  = 8'h21;
   localparam logic [7:0] RT_CLASS_IN   = 8'ha1;
   localparam logic [6:0] CFG_TOGGLE_EP = 7'h1e;

   typedef struct packed {
      logic [15:0] value;
      logic [15:0] index;
      logic [7:0]  offset;
      logic [7:0]  length;
      logic        valid;
   } desc_entry_type;

   localparam desc_entry_type DESC_TABLE [16] = '{
      '{16'h0100, 16'h0000, 8'd0,   8'd18, 1'b1},
      '{16'h0200, 16'h0000, 8'd18,  8'd59, 1'b1},
      '{16'h2200, 16'h0000, 8'd77,  8'd64, 1'b1},
      '{16'h2100, 16'h0000, 8'd36,  8'd9,  1'b1},
      '{16'h2200, 16'h0001, 8'd141, 8'd52, 1'b1},
      '{16'h2100, 16'h0001, 8'd61,  8'd9,  1'b1},
      '{16'h0300, 16'h0000, 8'd193, 8'd4,  1'b1},
      '{16'h0301, 16'h0409, 8'd197, 8'd16, 1'b1},
      '{16'h0302, 16'h0409, 8'd213, 8'd16, 1'b1},
      '{16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0},
      '{16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0},
      '{16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0},
      '{16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0},
      '{16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0},
      '{16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0},
      '{16'h0000, 16'h0000, 8'd0,   8'd0,  1'b0}
   };

   localparam logic [7:0] ROM_IMAGE [ROM_USED] = '{
      8'h12, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h20, 8'hc0, 8'h16,
      8'h82, 8'h04, 8'h00, 8'h01, 8'h01, 8'h02, 8'h00, 8'h01,
      8'h09, 8'h02, 8'h3b, 8'h00, 8'h02, 8'h01, 8'h00, 8'h80, 8'h32,
      8'h09, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
      8'h09, 8'h21, 8'h01, 8'h01, 8'h00, 8'h01, 8'h22, 8'h40, 8'h00,
      8'h07, 8'h05, 8'h83, 8'h03, 8'h08, 8'h00, 8'h0a,
      8'h09, 8'h04, 8'h01, 8'h00, 8'h01, 8'h03, 8'h01, 8'h02, 8'h00,
      8'h09, 8'h21, 8'h01, 8'h01, 8'h00, 8'h01, 8'h22, 8'h34, 8'h00,
      8'h07, 8'h05, 8'h84, 8'h03, 8'h08, 8'h00, 8'h0a,
      8'h05, 8'h01, 8'h09, 8'h06, 8'ha1, 8'h01,
      8'h05, 8'h07, 8'h19, 8'he0, 8'h29, 8'he7, 8'h15, 8'h00, 8'h25, 8'h01,
      8'h95, 8'h08, 8'h75, 8'h01, 8'h81, 8'h02,
      8'h95, 8'h01, 8'h75, 8'h08, 8'h81, 8'h01,
      8'h05, 8'h07, 8'h19, 8'h00, 8'h29, 8'hff, 8'h15, 8'h00, 8'h26, 8'hff,
      8'h00, 8'h95, 8'h06, 8'h75, 8'h08, 8'h81, 8'h00,
      8'h05, 8'h08, 8'h19, 8'h01, 8'h29, 8'h05, 8'h95, 8'h05, 8'h75, 8'h01,
      8'h91, 8'h02,
      8'h95, 8'h01, 8'h75, 8'h03, 8'h91, 8'h01,
      8'hc0,
      8'h05, 8'h01, 8'h09, 8'h02, 8'ha1, 8'h01, 8'h09, 8'h01, 8'ha1, 8'h00,
      8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h05, 8'h15, 8'h00, 8'h25, 8'h01,
      8'h95, 8'h05, 8'h75, 8'h01, 8'h81, 8'h02,
      8'h95, 8'h01, 8'h75, 8'h03, 8'h81, 8'h01,
      8'h05, 8'h01, 8'h09, 8'h30, 8'h09, 8'h31, 8'h09, 8'h38, 8'h15, 8'h81,
      8'h25, 8'h7f, 8'h75, 8'h08, 8'h95, 8'h03, 8'h81, 8'h06,
      8'hc0, 8'hc0,
      8'h04, 8'h03, 8'h09, 8'h04,
      8'h10, 8'h03, 8'h5b, 8'h00, 8'h65, 8'h00, 8'h6d, 8'h00, 8'h61, 8'h00,
      8'h69, 8'h00, 8'h6c, 8'h00, 8'h5d, 8'h00,
      8'h10, 8'h03, 8'h51, 8'h00, 8'h75, 8'h00, 8'h63, 8'h00, 8'h6b, 8'h00,
      8'h65, 8'h00, 8'h79, 8'h00, 8'h33, 8'h00
   };

   function automatic logic [7:0] rom_byte(input logic [7:0] addr);
      logic [7:0] b;
      b = 8'h00;
      if (addr < 8'(ROM_USED)) begin
         b = ROM_IMAGE[addr];
      end
      return b;
   endfunction

endpackage

>>> rtl/core/usb_hid_control_endpoint.sv
// Endpoint-0 control request handler for a keyboard-plus-mouse HID device.
// req_*: one event per request (tuser = opcode: setup, IN bank free, OUT data,
// bus reset) with the setup fields and the first OUT byte in tdata.
// rsp_*: one to 32 results per event; tuser = kind, tlast marks the last
// result of the event, tdata carries the data byte and the status fields.
// csr_*: index 0 writes the vendor id, index 1 the product id; other indexes
// ignored.
// An event is taken into a holding register and its first result is loaded
// into the output register once that register is free. An IN event with data
// first passes through S_EXEC and then streams one byte per cycle, while
// rsp_tready does not stall, out of the descriptor RAM; GET_STATUS gives its
// second byte from S_STAT2.
// One event is in work at a time.
// After reset the descriptor RAM is loaded, one byte a cycle into all 256
// addresses, with req_tready low; CSR writes are taken throughout.
// A stalled rsp_tready holds the result register and the sequencer; the next
// event is still taken into the holding register while a result waits.
module usb_hid_control_endpoint
   import uhid_pkg::*;
#(
   parameter int EP0_PACKET_BYTES   = EP0_PACKET_BYTES_DEF,
   parameter int NUM_ENDPOINTS      = NUM_ENDPOINTS_DEF,
   parameter int DESC_TABLE_ENTRIES = DESC_TABLE_ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // type[7:0] code[15:8] value[31:16] index[47:32] length[63:48] out_byte[71:64]
   input  logic [71:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data_byte[7:0] device_address[14:8] address_enabled[15] configuration[23:16]
   // leds[31:24] stall_mask[38:32] toggle_reset_mask[45:39] zero[47:46]
   output logic [47:0] rsp_tdata,
   // resp_kind[1:0]
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int         PKT  = (EP0_PACKET_BYTES > MAX_PACKET) ? MAX_PACKET : EP0_PACKET_BYTES;
   localparam logic [7:0] PKT8 = 8'(PKT);

   localparam logic [2:0] S_FILL  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_STAT2 = 3'd3;
   localparam logic [2:0] S_SEND  = 3'd4;

   function automatic logic [6:0] ep_mask(input logic [6:0] ep);
      logic [6:0] m;
      m = 7'd0;
      if (ep >= 7'd1 && ep <= 7'(NUM_ENDPOINTS) && ep <= 7'd6) begin
         m = 7'(1) << ep[2:0];
      end
      return m;
   endfunction

   logic [2:0]  state_ff, state_in;
   logic [7:0]  fill_ff, fill_in;
   logic [1:0]  op_ff, op_in;
   logic [71:0] item_ff, item_in;
   logic [15:0] vid_ff, pid_ff;
   logic [6:0]  addr_ff, addr_in;
   logic        on_ff, on_in;
   logic [7:0]  cfg_ff, cfg_in;
   logic [7:0]  kidle_ff, kidle_in;
   logic [7:0]  kproto_ff, kproto_in;
   logic [7:0]  led_ff, led_in;
   logic [6:0]  halt_ff, halt_in;
   logic [6:0]  toggle_ff, toggle_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic [7:0]  rem_ff, rem_in;
   logic        active_ff, active_in;
   logic        pend_ff, pend_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        full_ff, full_in;
   logic        rvalid_ff, rvalid_in;
   logic [1:0]  rkind_ff, rkind_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic        rlast_ff, rlast_in;

   logic        out_free;
   logic [7:0]  ram_q, rom_q;
   logic        ram_we;
   logic        em_valid, em_last, hit, handled;
   logic [1:0]  em_kind;
   logic [7:0]  em_data, hit_off, hit_len, lenc, n, t, c;
   logic [15:0] v, ix, len;
   logic        st;

   assign t   = item_ff[7:0];
   assign c   = item_ff[15:8];
   assign v   = item_ff[31:16];
   assign ix  = item_ff[47:32];
   assign len = item_ff[63:48];

   assign out_free   = !rvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign ram_we     = (state_ff == S_FILL);

   uhid_ram #(.WIDTH(8), .DEPTH(ROM_DEPTH)) u_rom (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff),
      .wr_data (rom_byte(fill_ff)),
      .rd_addr (ptr_in),
      .rd_data (ram_q)
   );

   always_comb begin
      unique case (ptr_ff)
         8'd7:    rom_q = 8'(EP0_PACKET_BYTES);
         8'd8:    rom_q = vid_ff[7:0];
         8'd9:    rom_q = vid_ff[15:8];
         8'd10:   rom_q = pid_ff[7:0];
         8'd11:   rom_q = pid_ff[15:8];
         default: rom_q = ram_q;
      endcase
   end

   always_comb begin
      hit     = 1'b0;
      hit_off = 8'd0;
      hit_len = 8'd0;
      for (int i = DESC_TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (DESC_TABLE[i].valid && DESC_TABLE[i].value == v && DESC_TABLE[i].index == ix) begin
            hit     = 1'b1;
            hit_off = DESC_TABLE[i].offset;
            hit_len = DESC_TABLE[i].length;
         end
      end
      lenc = (len < 16'd255) ? len[7:0] : 8'd255;
      if (lenc > hit_len) begin
         lenc = hit_len;
      end
      n  = (rem_ff < PKT8) ? rem_ff : PKT8;
      st = (t == RT_EP_IN) && ((halt_ff & ep_mask({3'd0, ix[3:0]})) != 7'd0);
   end

   always_comb begin
      state_in  = state_ff;
      fill_in   = fill_ff;
      op_in     = op_ff;
      item_in   = item_ff;
      addr_in   = addr_ff;
      on_in     = on_ff;
      cfg_in    = cfg_ff;
      kidle_in  = kidle_ff;
      kproto_in = kproto_ff;
      led_in    = led_ff;
      halt_in   = halt_ff;
      toggle_in = toggle_ff;
      ptr_in    = ptr_ff;
      rem_in    = rem_ff;
      active_in = active_ff;
      pend_in   = pend_ff;
      cnt_in    = cnt_ff;
      full_in   = full_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rkind_in  = rkind_ff;
      rdata_in  = rdata_ff;
      rlast_in  = rlast_ff;
      em_valid  = 1'b0;
      em_kind   = KIND_NONE;
      em_data   = 8'd0;
      em_last   = 1'b1;
      handled   = 1'b0;

      unique case (state_ff)
         S_FILL: begin
            fill_in = fill_ff + 8'd1;
            if (fill_ff == 8'd255) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               item_in  = req_tdata;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               toggle_in = 7'd0;
               state_in  = S_IDLE;
               em_valid  = 1'b1;
               unique case (op_ff)
                  OP_SETUP: begin
                     active_in = 1'b0;
                     pend_in   = 1'b0;
                     priority if (c == REQ_GET_DESCRIPTOR) begin
                        if (hit) begin
                           ptr_in    = hit_off;
                           rem_in    = lenc;
                           active_in = 1'b1;
                        end else begin
                           em_kind = KIND_STALL;
                        end
                     end else if (c == REQ_SET_ADDRESS) begin
                        addr_in = v[6:0];
                        on_in   = 1'b1;
                        em_kind = KIND_ZLP;
                     end else if (c == REQ_SET_CONFIG && t == RT_STD_OUT) begin
                        cfg_in    = v[7:0];
                        halt_in   = 7'd0;
                        toggle_in = CFG_TOGGLE_EP;
                        em_kind   = KIND_ZLP;
                     end else if (c == REQ_GET_CONFIG && t == RT_STD_IN) begin
                        em_kind = KIND_DATA;
                        em_data = cfg_ff;
                     end else if (c == REQ_GET_STATUS) begin
                        em_kind  = KIND_DATA;
                        em_data  = {7'd0, st};
                        em_last  = 1'b0;
                        state_in = S_STAT2;
                     end else begin
                        if ((c == REQ_CLEAR_FEATURE || c == REQ_SET_FEATURE) && t == RT_EP_OUT
                            && v == 16'd0 && ep_mask(ix[6:0]) != 7'd0) begin
                           handled = 1'b1;
                           em_kind = KIND_ZLP;
                           if (c == REQ_SET_FEATURE) begin
                              halt_in = halt_ff | ep_mask(ix[6:0]);
                           end else begin
                              halt_in   = halt_ff & ~ep_mask(ix[6:0]);
                              toggle_in = ep_mask(ix[6:0]);
                           end
                        end
                        if (!handled && ix == 16'd0) begin
                           if (t == RT_CLASS_IN && c == CLS_GET_IDLE) begin
                              handled = 1'b1;
                              em_kind = KIND_DATA;
                              em_data = kidle_ff;
                           end else if (t == RT_CLASS_IN && c == CLS_GET_PROTOCOL) begin
                              handled = 1'b1;
                              em_kind = KIND_DATA;
                              em_data = kproto_ff;
                           end else if (t == RT_CLASS_OUT && c == CLS_SET_REPORT) begin
                              handled = 1'b1;
                              pend_in = 1'b1;
                           end else if (t == RT_CLASS_OUT && c == CLS_SET_IDLE) begin
                              handled  = 1'b1;
                              kidle_in = v[15:8];
                              em_kind  = KIND_ZLP;
                           end else if (t == RT_CLASS_OUT && c == CLS_SET_PROTOCOL) begin
                              handled   = 1'b1;
                              kproto_in = v[7:0];
                              em_kind   = KIND_ZLP;
                           end
                        end
                        if (!handled && ix == 16'd1 && t == RT_CLASS_OUT
                            && (c == CLS_SET_IDLE || c == CLS_SET_PROTOCOL)) begin
                           handled = 1'b1;
                           em_kind = KIND_ZLP;
                        end
                        if (!handled) begin
                           em_kind = KIND_STALL;
                        end
                     end
                  end
                  OP_IN: begin
                     if (active_ff) begin
                        if (n == 8'd0) begin
                           em_kind   = KIND_ZLP;
                           active_in = 1'b0;
                        end else begin
                           em_valid = 1'b0;
                           cnt_in   = n[5:0];
                           full_in  = (n == PKT8);
                           state_in = S_SEND;
                        end
                     end
                  end
                  OP_OUT: begin
                     if (active_ff) begin
                        active_in = 1'b0;
                     end else if (pend_ff) begin
                        led_in  = item_ff[71:64];
                        pend_in = 1'b0;
                        em_kind = KIND_ZLP;
                     end
                  end
                  OP_RESET: begin
                     addr_in   = 7'd0;
                     on_in     = 1'b0;
                     cfg_in    = 8'd0;
                     halt_in   = 7'd0;
                     active_in = 1'b0;
                     pend_in   = 1'b0;
                  end
               endcase
            end
         end
         S_STAT2: begin
            if (out_free) begin
               em_valid = 1'b1;
               em_kind  = KIND_DATA;
               state_in = S_IDLE;
            end
         end
         S_SEND: begin
            if (out_free) begin
               em_valid = 1'b1;
               em_kind  = KIND_DATA;
               em_data  = rom_q;
               em_last  = (cnt_ff == 6'd1);
               ptr_in   = ptr_ff + 8'd1;
               rem_in   = rem_ff - 8'd1;
               cnt_in   = cnt_ff - 6'd1;
               if (cnt_ff == 6'd1) begin
                  active_in = (rem_ff != 8'd1) || full_ff;
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (em_valid) begin
         rvalid_in = 1'b1;
         rkind_in  = em_kind;
         rdata_in  = em_data;
         rlast_in  = em_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_FILL;
         fill_ff   <= 8'd0;
         vid_ff    <= 16'd5824;
         pid_ff    <= 16'd1154;
         addr_ff   <= 7'd0;
         on_ff     <= 1'b0;
         cfg_ff    <= 8'd0;
         kidle_ff  <= 8'd125;
         kproto_ff <= 8'd1;
         led_ff    <= 8'd0;
         halt_ff   <= 7'd0;
         toggle_ff <= 7'd0;
         ptr_ff    <= 8'd0;
         rem_ff    <= 8'd0;
         active_ff <= 1'b0;
         pend_ff   <= 1'b0;
         cnt_ff    <= 6'd0;
         full_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         fill_ff   <= fill_in;
         addr_ff   <= addr_in;
         on_ff     <= on_in;
         cfg_ff    <= cfg_in;
         kidle_ff  <= kidle_in;
         kproto_ff <= kproto_in;
         led_ff    <= led_in;
         halt_ff   <= halt_in;
         toggle_ff <= toggle_in;
         ptr_ff    <= ptr_in;
         rem_ff    <= rem_in;
         active_ff <= active_in;
         pend_ff   <= pend_in;
         cnt_ff    <= cnt_in;
         full_ff   <= full_in;
         rvalid_ff <= rvalid_in;
         if (csr_valid && csr_index == CSR_VID) begin
            vid_ff <= csr_data;
         end
         if (csr_valid && csr_index == CSR_PID) begin
            pid_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      item_ff  <= item_in;
      rkind_ff <= rkind_in;
      rdata_ff <= rdata_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tuser  = rkind_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {2'b00, toggle_ff, halt_ff & 7'h7e, led_ff, cfg_ff, on_ff, addr_ff,
                        rdata_ff};

   a_send_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEND |-> (cnt_ff != 6'd0 && cnt_ff <= 6'(PKT)))
      else $error("send count out of range");

   a_fill_quiet: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FILL |-> !rvalid_ff && !req_tready)
      else $error("activity during descriptor load");

   a_send_emits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SEND && out_free |=> rvalid_ff && rkind_ff == KIND_DATA)
      else $error("send step lost a byte");

   a_stat_pair: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_STAT2 |-> rvalid_ff && !rlast_ff)
      else $error("status first byte missing");

endmodule

>>> rtl/core/uhid_ram.sv
module uhid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> tb/tb_usb_hid_control_endpoint.sv
`timescale 1ns / 1ps

module tb_usb_hid_control_endpoint;
   import uhid_pkg::*;

   typedef struct {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        last;
      logic [6:0]  addr;
      logic        addr_on;
      logic [7:0]  cfg;
      logic [7:0]  leds;
      logic [6:0]  halt;
      logic [6:0]  toggle;
   } ep0_rsp_type;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  rtype;
      logic [7:0]  code;
      logic [15:0] value;
      logic [15:0] index;
      logic [15:0] length;
      logic [7:0]  ob;
      logic        chk;
      logic [1:0]  xkind;
      logic [7:0]  xdata;
   } ep0_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   usb_hid_control_endpoint i_dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // shadow of the endpoint state
   logic [7:0]  m_rom [256];
   logic [6:0]  m_addr;
   logic        m_addr_on;
   logic [7:0]  m_cfg, m_kidle, m_kproto, m_midle, m_mproto, m_leds;
   logic [6:0]  m_halt;
   logic [7:0]  m_ptr, m_rem;
   logic        m_xfer, m_rpt;
   logic [15:0] m_vid, m_pid;

   ep0_rsp_type pending_rsp[$];
   ep0_rsp_type step_rsp[$];
   int          errors = 0;
   int          mismatches = 0;
   logic        hold_rsp = 1'b0;
   logic        no_idle = 1'b0;
   logic        hold_active = 1'b0;

   task automatic put_ids();
      m_rom[8]  = m_vid[7:0];
      m_rom[9]  = m_vid[15:8];
      m_rom[10] = m_pid[7:0];
      m_rom[11] = m_pid[15:8];
   endtask

   task automatic model_init();
      for (int i = 0; i < 256; i++) m_rom[i] = (i < ROM_USED) ? ROM_IMAGE[i] : 8'h00;
      m_vid = 16'd5824;
      m_pid = 16'd1154;
      put_ids();
      m_addr = '0; m_addr_on = 0; m_cfg = '0;
      m_kidle = 8'd125; m_kproto = 8'd1; m_midle = 8'd125; m_mproto = 8'd1;
      m_leds = '0; m_halt = '0; m_ptr = '0; m_rem = '0; m_xfer = 0; m_rpt = 0;
   endtask

   function automatic logic [6:0] ep_mask(input int ep);
      if (ep < 1 || ep > 6) return 7'd0;
      return 7'(1 << ep);
   endfunction

   task automatic push(input logic [1:0] k, input logic [7:0] d);
      ep0_rsp_type r;
      r = '{default: '0};
      r.kind = k;
      r.data = d;
      step_rsp.push_back(r);
   endtask

   task automatic serve_setup(input ep0_req_type q, inout logic [6:0] tog);
      int n;
      logic [6:0] b;
      if (q.code == REQ_GET_DESCRIPTOR) begin
         for (int i = 0; i < DESC_TABLE_ENTRIES_DEF; i++) begin
            if (DESC_TABLE[i].valid && DESC_TABLE[i].value == q.value &&
                DESC_TABLE[i].index == q.index) begin
               n = (q.length < 255) ? q.length : 255;
               if (n > DESC_TABLE[i].length) n = DESC_TABLE[i].length;
               m_ptr = DESC_TABLE[i].offset;
               m_rem = 8'(n);
               m_xfer = 1;
               push(KIND_NONE, 0);
               return;
            end
         end
         push(KIND_STALL, 0);
         return;
      end
      if (q.code == REQ_SET_ADDRESS) begin
         m_addr = q.value[6:0]; m_addr_on = 1; push(KIND_ZLP, 0); return;
      end
      if (q.code == REQ_SET_CONFIG && q.rtype == RT_STD_OUT) begin
         m_cfg = q.value[7:0]; m_halt = '0; tog = CFG_TOGGLE_EP; push(KIND_ZLP, 0); return;
      end
      if (q.code == REQ_GET_CONFIG && q.rtype == RT_STD_IN) begin
         push(KIND_DATA, m_cfg); return;
      end
      if (q.code == REQ_GET_STATUS) begin
         push(KIND_DATA, (q.rtype == RT_EP_IN && (m_halt & ep_mask(q.index[3:0])) != 0)
              ? 8'd1 : 8'd0);
         push(KIND_DATA, 0);
         return;
      end
      if ((q.code == REQ_CLEAR_FEATURE || q.code == REQ_SET_FEATURE) &&
          q.rtype == RT_EP_OUT && q.value == 0) begin
         b = ep_mask(q.index[6:0]);
         if (b != 0) begin
            if (q.code == REQ_SET_FEATURE) m_halt = m_halt | b;
            else begin
               m_halt = m_halt & ~b; tog = b;
            end
            push(KIND_ZLP, 0);
            return;
         end
      end
      if (q.index == 0) begin
         if (q.rtype == RT_CLASS_IN) begin
            if (q.code == CLS_GET_IDLE) begin push(KIND_DATA, m_kidle); return; end
            if (q.code == CLS_GET_PROTOCOL) begin push(KIND_DATA, m_kproto); return; end
         end
         if (q.rtype == RT_CLASS_OUT) begin
            if (q.code == CLS_SET_REPORT) begin m_rpt = 1; push(KIND_NONE, 0); return; end
            if (q.code == CLS_SET_IDLE) begin
               m_kidle = q.value[15:8]; push(KIND_ZLP, 0); return;
            end
            if (q.code == CLS_SET_PROTOCOL) begin
               m_kproto = q.value[7:0]; push(KIND_ZLP, 0); return;
            end
         end
      end
      if (q.index == 1 && q.rtype == RT_CLASS_OUT) begin
         if (q.code == CLS_SET_IDLE) begin m_midle = q.value[15:8]; push(KIND_ZLP, 0); return; end
         if (q.code == CLS_SET_PROTOCOL) begin
            m_mproto = q.value[7:0]; push(KIND_ZLP, 0); return;
         end
      end
      push(KIND_STALL, 0);
   endtask

   task automatic predict_event(input ep0_req_type q);
      logic [6:0] tog;
      int n;
      tog = '0;
      step_rsp.delete();
      case (q.op)
         OP_SETUP: begin
            m_xfer = 0; m_rpt = 0;
            serve_setup(q, tog);
         end
         OP_IN: begin
            if (m_xfer) begin
               n = (m_rem < MAX_PACKET) ? m_rem : MAX_PACKET;
               if (n == 0) push(KIND_ZLP, 0);
               for (int k = 0; k < n; k++) begin
                  push(KIND_DATA, m_rom[m_ptr]);
                  m_ptr = m_ptr + 8'd1;
               end
               m_rem = m_rem - 8'(n);
               m_xfer = (m_rem != 0) || (n == MAX_PACKET);
            end
         end
         OP_OUT: begin
            if (m_xfer) m_xfer = 0;
            else if (m_rpt) begin
               m_leds = q.ob; m_rpt = 0; push(KIND_ZLP, 0);
            end
         end
         default: begin
            m_addr = '0; m_addr_on = 0; m_cfg = '0; m_halt = '0; m_xfer = 0; m_rpt = 0;
         end
      endcase
      if (step_rsp.size() == 0) push(KIND_NONE, 0);
      foreach (step_rsp[k]) begin
         step_rsp[k].last = (k == step_rsp.size() - 1);
         step_rsp[k].addr = m_addr;
         step_rsp[k].addr_on = m_addr_on;
         step_rsp[k].cfg = m_cfg;
         step_rsp[k].leds = m_leds;
         step_rsp[k].halt = m_halt & 7'h7e;
         step_rsp[k].toggle = tog;
         if (q.chk && k == 0 && (step_rsp[k].kind !== q.xkind || step_rsp[k].data !== q.xdata))
         begin
            errors++;
            if (mismatches++ < 10)
               $display("directed row op %0d code %h: exp kind %0d data %h, got kind %0d data %h",
                        q.op, q.code, q.xkind, q.xdata, step_rsp[k].kind, step_rsp[k].data);
         end
         pending_rsp.push_back(step_rsp[k]);
      end
   endtask

   task automatic idle_gap();
      if (!no_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_event(input ep0_req_type q);
      idle_gap();
      req_tvalid <= 1'b1;
      req_tuser  <= q.op;
      req_tdata  <= {q.ob, q.length, q.index, q.value, q.code, q.rtype};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_event(q);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_VID) m_vid = v;
      else m_pid = v;
      put_ids();
      @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   function automatic ep0_req_type mk(input logic [1:0] op, input logic [7:0] rt,
                                      input logic [7:0] cd, input logic [15:0] v,
                                      input logic [15:0] ix, input logic [15:0] ln,
                                      input logic [7:0] ob, input logic chk,
                                      input logic [1:0] xk, input logic [7:0] xd);
      ep0_req_type q;
      q = '{op, rt, cd, v, ix, ln, ob, chk, xk, xd};
      return q;
   endfunction

   function automatic ep0_req_type rand_setup();
      ep0_req_type q;
      int e;
      q = mk(OP_SETUP, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
             16'($urandom), 8'($urandom), 0, 0, 0);
      case ($urandom_range(0, 11))
         0, 1, 2: begin
            e = $urandom_range(0, 9);
            q.code = REQ_GET_DESCRIPTOR;
            if (e < 9) begin
               q.value = DESC_TABLE[e].value; q.index = DESC_TABLE[e].index;
            end
            if ($urandom_range(0, 1)) q.length = 16'($urandom_range(0, 300));
         end
         3: begin q.code = REQ_SET_ADDRESS; end
         4: begin q.code = REQ_SET_CONFIG; q.rtype = RT_STD_OUT; end
         5: begin q.code = REQ_GET_CONFIG; q.rtype = RT_STD_IN; end
         6: begin
            q.code = REQ_GET_STATUS;
            if ($urandom_range(0, 1)) q.rtype = RT_EP_IN;
         end
         7: begin
            q.code = $urandom_range(0, 1) ? REQ_SET_FEATURE : REQ_CLEAR_FEATURE;
            q.rtype = RT_EP_OUT; q.value = 0; q.index = 16'($urandom_range(0, 8));
         end
         8, 9: begin
            q.rtype = $urandom_range(0, 1) ? RT_CLASS_OUT : RT_CLASS_IN;
            q.index = 16'($urandom_range(0, 2));
            q.code = 8'($urandom_range(2, 11));
         end
         default: ;
      endcase
      return q;
   endfunction

   ep0_req_type dir_rows[$];

   initial begin
      ep0_req_type q;
      int r;
      model_init();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      dir_rows = '{
         mk(OP_IN, 0, 0, 0, 0, 0, 0, 1, KIND_NONE, 0),
         mk(OP_OUT, 0, 0, 0, 0, 0, 8'hff, 1, KIND_NONE, 0),
         mk(OP_SETUP, RT_STD_IN, REQ_GET_CONFIG, 0, 0, 0, 0, 1, KIND_DATA, 0),
         mk(OP_SETUP, RT_CLASS_IN, CLS_GET_IDLE, 0, 0, 0, 0, 1, KIND_DATA, 125),
         mk(OP_SETUP, RT_CLASS_IN, CLS_GET_PROTOCOL, 0, 0, 0, 0, 1, KIND_DATA, 1),
         mk(OP_SETUP, 8'hff, 8'hff, 16'hffff, 16'hffff, 16'hffff, 0, 1, KIND_STALL, 0),
         mk(OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, 16'h0100, 0, 16'hffff, 0, 1, KIND_NONE, 0),
         mk(OP_IN, 0, 0, 0, 0, 0, 0, 1, KIND_DATA, 8'h12),
         mk(OP_IN, 0, 0, 0, 0, 0, 0, 1, KIND_NONE, 0),
         mk(OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, 16'h2200, 0, 16'd64, 0, 0, 0, 0),
         mk(OP_IN, 0, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(OP_IN, 0, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(OP_IN, 0, 0, 0, 0, 0, 0, 1, KIND_ZLP, 0),
         mk(OP_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, 16'h0200, 0, 16'd40, 0, 0, 0, 0),
         mk(OP_IN, 0, 0, 0, 0, 0, 0, 0, 0, 0),
         mk(OP_OUT, 0, 0, 0, 0, 0, 8'h55, 1, KIND_NONE, 0),
         mk(OP_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'h00ff, 0, 0, 0, 1, KIND_ZLP, 0),
         mk(OP_SETUP, RT_STD_OUT, REQ_SET_CONFIG, 16'h0001, 0, 0, 0, 1, KIND_ZLP, 0),
         mk(OP_SETUP, RT_EP_OUT, REQ_SET_FEATURE, 0, 16'd6, 0, 0, 1, KIND_ZLP, 0),
         mk(OP_SETUP, RT_EP_IN, REQ_GET_STATUS, 0, 16'h0086, 0, 0, 1, KIND_DATA, 1),
         mk(OP_SETUP, RT_EP_OUT, REQ_CLEAR_FEATURE, 0, 16'd6, 0, 0, 1, KIND_ZLP, 0),
         mk(OP_SETUP, RT_CLASS_OUT, CLS_SET_REPORT, 0, 0, 0, 0, 1, KIND_NONE, 0),
         mk(OP_OUT, 0, 0, 0, 0, 0, 8'ha5, 1, KIND_ZLP, 0),
         mk(OP_SETUP, RT_CLASS_OUT, CLS_SET_IDLE, 16'hff00, 16'd1, 0, 0, 1, KIND_ZLP, 0),
         mk(OP_RESET, 0, 0, 0, 0, 0, 0, 1, KIND_NONE, 0)
      };
      foreach (dir_rows[i]) send_event(dir_rows[i]);
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin write_csr(CSR_VID, 16'h0000); write_csr(CSR_PID, 16'hffff); end
            1: begin write_csr(CSR_VID, 16'hffff); write_csr(CSR_PID, 16'h0000); end
            2: begin write_csr(CSR_VID, 16'($urandom)); write_csr(CSR_PID, 16'($urandom)); end
            default: begin
               write_csr(CSR_VID, 16'd5824); write_csr(CSR_PID, 16'd1154);
               no_idle = 1'b1;
            end
         endcase
         if (ph == 1) hold_rsp = 1'b1;
         for (int n = 0; n < 87; n++) begin
            r = $urandom_range(0, 9);
            if (r < 4) q = rand_setup();
            else q = mk(r < 7 ? OP_IN : (r < 9 ? OP_OUT : OP_RESET), 8'($urandom),
                        8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        8'($urandom), 0, 0, 0);
            if (r == 9 && $urandom_range(0, 2) != 0) q = rand_setup();
            send_event(q);
         end
         drain();
      end
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // receiver: random stalls, one long hold-off when requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_active) begin
            hold_active <= 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      ep0_rsp_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            if (mismatches++ < 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_tuser !== e.kind || rsp_tdata[7:0] !== e.data || rsp_tlast !== e.last ||
                rsp_tdata[14:8] !== e.addr || rsp_tdata[15] !== e.addr_on ||
                rsp_tdata[23:16] !== e.cfg || rsp_tdata[31:24] !== e.leds ||
                rsp_tdata[38:32] !== e.halt || rsp_tdata[45:39] !== e.toggle) begin
               errors++;
               if (mismatches++ < 10)
                  $display("mismatch: exp kind %0d data %h last %b addr %h/%b cfg %h leds %h halt %h tog %h; got kind %0d tdata %h last %b",
                           e.kind, e.data, e.last, e.addr, e.addr_on, e.cfg, e.leds, e.halt,
                           e.toggle, rsp_tuser, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/core/uhid_pkg.sv
rtl/core/uhid_ram.sv
rtl/core/usb_hid_control_endpoint.sv
tb/tb_usb_hid_control_endpoint.sv
